/* sv/htp_pkg.sv */
// Shared types, widths, codes and reset values for the heading turn PID core.
`timescale 1ns / 1ps

package htp_pkg;

	localparam int CMD_W      = 1;
	localparam int DIR_W      = 2;
	localparam int HEADING_W  = 17;
	localparam int DRIVE_W    = 16;
	localparam int TARGET_W   = 9;
	localparam int COEF_W     = 32;
	localparam int LIMIT_W    = 15;
	localparam int DONE_WIN_W = 12;
	localparam int SNAP_WIN_W = 6;
	localparam int ACC_W      = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 48;

	localparam int ANGLE_FRAC_BITS_DEF = 6;
	localparam int COEF_FRAC_BITS_DEF  = 24;

	localparam int DEG_QUARTER       = 90;
	localparam int DEG_HALF          = 180;
	localparam int DEG_THREE_QUARTER = 270;
	localparam int DEG_FULL          = 360;

	localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd0;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
	localparam logic [DIR_W-1:0] DIR_BACK  = 2'd2;

	localparam logic signed [COEF_W-1:0] COEF_NOW_RST   = 32'sd838907403;
	localparam logic signed [COEF_W-1:0] COEF_PREV_RST  = -32'sd838814197;
	localparam logic signed [COEF_W-1:0] COEF_PREV2_RST = 32'sd0;
	localparam logic [LIMIT_W-1:0]       DRIVE_LIMIT_RST = 15'd6000;
	localparam logic [DONE_WIN_W-1:0]    DONE_WINDOW_RST = 12'd7;
	localparam logic [SNAP_WIN_W-1:0]    SNAP_WINDOW_RST = 6'd2;

	typedef enum logic [CMD_W-1:0] {
		CMD_START  = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COEF_NOW    = 3'd0,
		CFG_COEF_PREV   = 3'd1,
		CFG_COEF_PREV2  = 3'd2,
		CFG_DRIVE_LIMIT = 3'd3,
		CFG_DONE_WINDOW = 3'd4,
		CFG_SNAP_WINDOW = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_START,
		KIND_IDLE,
		KIND_PID
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic  done;
		logic  neg;
	} item_ctl_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] coef_now;
		logic signed [COEF_W-1:0] coef_prev;
		logic signed [COEF_W-1:0] coef_prev2;
		logic [LIMIT_W-1:0]       drive_limit;
		logic [DONE_WIN_W-1:0]    done_window;
		logic [SNAP_WIN_W-1:0]    snap_window;
	} cfg_t;

	// Width of the whole-degree target before reduction.
	function automatic int turn_w(input int a);
		turn_w = ((HEADING_W > 10 + a) ? HEADING_W : 10 + a) + 1 - a;
	endfunction

	// Width of the signed heading error.
	function automatic int err_w(input int a);
		err_w = ((TARGET_W + a > HEADING_W) ? TARGET_W + a : HEADING_W) + 2;
	endfunction

endpackage

/* sv/htp_snap.sv */
// First stage: whole-degree target from a start transfer, snapped and prepared for mod 360.
`timescale 1ns / 1ps

module htp_snap #(
	parameter int ANGLE_FRAC_BITS = htp_pkg::ANGLE_FRAC_BITS_DEF,
	localparam int TW = htp_pkg::turn_w(ANGLE_FRAC_BITS)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_v,
	output logic                                  in_take,
	input  htp_pkg::cmd_t                         in_cmd,
	input  logic [htp_pkg::DIR_W-1:0]             in_dir,
	input  logic signed [htp_pkg::HEADING_W-1:0]  in_heading,
	input  logic [htp_pkg::SNAP_WIN_W-1:0]        snap_window,
	output logic                                  out_v,
	input  logic                                  out_take,
	output htp_pkg::cmd_t                         cmd_s2,
	output logic                                  neg_s2,
	output logic signed [htp_pkg::HEADING_W-1:0]  heading_s2,
	output logic signed [TW-1:0]                  tsn_s2,
	output logic [TW-1:0]                         q_s2
);

	localparam int VW = TW + ANGLE_FRAC_BITS;
	localparam int DW = TW + 2;
	localparam logic [VW-1:0] FRAC_MASK = (VW'(1) << ANGLE_FRAC_BITS) - VW'(1);
	localparam int RECIP = (1 << TW) / htp_pkg::DEG_FULL;

	logic                  v_s2;
	logic                  load;
	logic signed [VW-1:0]  step_c;
	logic signed [VW-1:0]  sum_c;
	logic signed [VW-1:0]  shr_c;
	logic                  rnd_c;
	logic signed [TW-1:0]  t_c;
	logic signed [DW-1:0]  td_c;
	logic signed [DW-1:0]  ws_c;
	logic signed [TW-1:0]  tsn_c;
	logic [TW-1:0]         n_c;
	logic [2*TW-1:0]       prod_c;

	function automatic logic near(input logic signed [DW-1:0] d,
	                              input logic signed [DW-1:0] w);
		near = (d <= w) && (d >= -w);
	endfunction

	assign in_take = !v_s2 || out_take;
	assign load    = in_v && in_take;
	assign out_v   = v_s2;

	always_comb begin
		case (in_dir)
			htp_pkg::DIR_RIGHT: step_c = -(VW'(htp_pkg::DEG_QUARTER) << ANGLE_FRAC_BITS);
			htp_pkg::DIR_LEFT:  step_c = VW'(htp_pkg::DEG_QUARTER) << ANGLE_FRAC_BITS;
			default:            step_c = VW'(htp_pkg::DEG_HALF) << ANGLE_FRAC_BITS;
		endcase
		sum_c = step_c + VW'(in_heading);
		shr_c = sum_c >>> ANGLE_FRAC_BITS;
		// The shift rounds down, so a negative value with a fraction gets one added to truncate toward zero.
		rnd_c = sum_c[VW-1] && (|(sum_c & FRAC_MASK));
		t_c   = shr_c[TW-1:0] + {{(TW-1){1'b0}}, rnd_c};
		td_c  = DW'(t_c);
		ws_c  = signed'(DW'(snap_window));
		if (near(td_c, ws_c)) begin
			tsn_c = '0;
		end else if (near(td_c - DW'(htp_pkg::DEG_QUARTER), ws_c)) begin
			tsn_c = TW'(htp_pkg::DEG_QUARTER);
		end else if (near(td_c - DW'(htp_pkg::DEG_HALF), ws_c)) begin
			tsn_c = TW'(htp_pkg::DEG_HALF);
		end else if (near(td_c - DW'(htp_pkg::DEG_THREE_QUARTER), ws_c)) begin
			tsn_c = TW'(htp_pkg::DEG_THREE_QUARTER);
		end else if (near(td_c - DW'(htp_pkg::DEG_FULL), ws_c)) begin
			tsn_c = '0;
		end else begin
			tsn_c = t_c;
		end
		n_c    = tsn_c[TW-1] ? -tsn_c : tsn_c;
		// Reciprocal estimate of the quotient by 360; it may come out one low.
		prod_c = (2*TW)'(n_c) * (2*TW)'(RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (in_take) begin
			v_s2 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_s2     <= in_cmd;
			neg_s2     <= (in_dir == htp_pkg::DIR_RIGHT);
			heading_s2 <= in_heading;
			tsn_s2     <= tsn_c;
			q_s2       <= prod_c[2*TW-1:TW];
		end
	end

endmodule

/* sv/htp_pid_err.sv */
// Second stage: target and error state, heading error and the three PID products.
`timescale 1ns / 1ps

module htp_pid_err #(
	parameter int ANGLE_FRAC_BITS = htp_pkg::ANGLE_FRAC_BITS_DEF,
	localparam int TW = htp_pkg::turn_w(ANGLE_FRAC_BITS),
	localparam int EW = htp_pkg::err_w(ANGLE_FRAC_BITS),
	localparam int PW = htp_pkg::COEF_W + EW
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_v,
	output logic                                  in_take,
	input  htp_pkg::cmd_t                         cmd_s2,
	input  logic                                  neg_s2,
	input  logic signed [htp_pkg::HEADING_W-1:0]  heading_s2,
	input  logic signed [TW-1:0]                  tsn_s2,
	input  logic [TW-1:0]                         q_s2,
	input  htp_pkg::cfg_t                         cfg,
	output logic                                  out_v,
	input  logic                                  out_take,
	output htp_pkg::item_ctl_t                    ctl_s3,
	output logic [htp_pkg::TARGET_W-1:0]          tgt_s3,
	output logic signed [PW-1:0]                  p0_s3,
	output logic signed [PW-1:0]                  p1_s3,
	output logic signed [PW-1:0]                  p2_s3
);

	logic                           v_s3;
	logic                           load;
	logic [htp_pkg::TARGET_W-1:0]   target_q;
	logic                           neg_q;
	logic                           active_q;
	logic signed [EW-1:0]           e1_q;
	logic signed [EW-1:0]           e2_q;

	logic [TW-1:0]                  n_c;
	logic [TW-1:0]                  q360_c;
	logic [TW-1:0]                  r_c;
	logic [htp_pkg::TARGET_W-1:0]   tgt_new_c;
	logic signed [EW-1:0]           tgt_e_c;
	logic signed [EW-1:0]           diff_c;
	logic signed [EW-1:0]           e_c;
	logic [EW-1:0]                  ae_c;
	logic                           done_c;
	logic signed [PW-1:0]           p0_c;
	logic signed [PW-1:0]           p1_c;
	logic signed [PW-1:0]           p2_c;
	htp_pkg::item_ctl_t             ctl_c;
	logic [htp_pkg::TARGET_W-1:0]   tgt_c;

	assign in_take = !v_s3 || out_take;
	assign load    = in_v && in_take;
	assign out_v   = v_s3;

	always_comb begin
		// True modulo 360 of the snapped target.
		n_c    = tsn_s2[TW-1] ? -tsn_s2 : tsn_s2;
		q360_c = q_s2 * TW'(htp_pkg::DEG_FULL);
		r_c    = n_c - q360_c;
		if (r_c >= TW'(htp_pkg::DEG_FULL)) begin
			r_c = r_c - TW'(htp_pkg::DEG_FULL);
		end
		if (tsn_s2[TW-1] && (r_c != '0)) begin
			r_c = TW'(htp_pkg::DEG_FULL) - r_c;
		end
		tgt_new_c = r_c[htp_pkg::TARGET_W-1:0];

		tgt_e_c = EW'(target_q) << ANGLE_FRAC_BITS;
		diff_c  = tgt_e_c - EW'(heading_s2);
		e_c     = neg_q ? -diff_c : diff_c;
		ae_c    = e_c[EW-1] ? -e_c : e_c;
		done_c  = ae_c < EW'(cfg.done_window);

		p0_c = PW'(cfg.coef_now) * PW'(e_c);
		p1_c = PW'(cfg.coef_prev) * PW'(e1_q);
		p2_c = PW'(cfg.coef_prev2) * PW'(e2_q);

		ctl_c.done = 1'b0;
		ctl_c.neg  = neg_q;
		tgt_c      = target_q;
		if (cmd_s2 == htp_pkg::CMD_START) begin
			ctl_c.kind = htp_pkg::KIND_START;
			ctl_c.neg  = neg_s2;
			tgt_c      = tgt_new_c;
		end else if (active_q) begin
			ctl_c.kind = htp_pkg::KIND_PID;
			ctl_c.done = done_c;
		end else begin
			ctl_c.kind = htp_pkg::KIND_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3     <= 1'b0;
			target_q <= '0;
			neg_q    <= 1'b0;
			active_q <= 1'b0;
			e1_q     <= '0;
			e2_q     <= '0;
		end else begin
			if (in_take) begin
				v_s3 <= in_v;
			end
			if (load) begin
				if (cmd_s2 == htp_pkg::CMD_START) begin
					target_q <= tgt_new_c;
					neg_q    <= neg_s2;
					active_q <= 1'b1;
					e1_q     <= '0;
					e2_q     <= '0;
				end else if (active_q) begin
					e2_q <= e1_q;
					e1_q <= e_c;
					if (done_c) begin
						active_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ctl_s3 <= ctl_c;
			tgt_s3 <= tgt_c;
			p0_s3  <= p0_c;
			p1_s3  <= p1_c;
			p2_s3  <= p2_c;
		end
	end

endmodule

/* sv/htp_accum.sv */
// Third stage: saturating 64-bit drive accumulator.
`timescale 1ns / 1ps

module htp_accum #(
	parameter int ANGLE_FRAC_BITS = htp_pkg::ANGLE_FRAC_BITS_DEF,
	localparam int EW = htp_pkg::err_w(ANGLE_FRAC_BITS),
	localparam int PW = htp_pkg::COEF_W + EW
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_v,
	output logic                               in_take,
	input  htp_pkg::item_ctl_t                 ctl_s3,
	input  logic [htp_pkg::TARGET_W-1:0]       tgt_s3,
	input  logic signed [PW-1:0]               p0_s3,
	input  logic signed [PW-1:0]               p1_s3,
	input  logic signed [PW-1:0]               p2_s3,
	output logic                               out_v,
	input  logic                               out_take,
	output htp_pkg::item_ctl_t                 ctl_s4,
	output logic [htp_pkg::TARGET_W-1:0]       tgt_s4,
	output logic signed [htp_pkg::ACC_W-1:0]   acc_s4
);

	localparam int SW = PW + 2;
	localparam int AW = htp_pkg::ACC_W;

	logic                 v_s4;
	logic                 load;
	logic signed [AW-1:0] acc_q;
	logic signed [SW-1:0] sum_c;
	logic signed [AW:0]   wide_c;
	logic signed [AW-1:0] sat_c;

	assign in_take = !v_s4 || out_take;
	assign load    = in_v && in_take;
	assign out_v   = v_s4;

	always_comb begin
		sum_c  = SW'(p0_s3) + SW'(p1_s3) + SW'(p2_s3);
		wide_c = (AW + 1)'(acc_q) + (AW + 1)'(sum_c);
		// The top two bits differ only when the sum left the 64-bit range.
		if (wide_c[AW] != wide_c[AW-1]) begin
			sat_c = wide_c[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
		end else begin
			sat_c = wide_c[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4  <= 1'b0;
			acc_q <= '0;
		end else begin
			if (in_take) begin
				v_s4 <= in_v;
			end
			if (load) begin
				case (ctl_s3.kind)
					htp_pkg::KIND_START: acc_q <= '0;
					htp_pkg::KIND_PID:   acc_q <= sat_c;
					default:             acc_q <= acc_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ctl_s4 <= ctl_s3;
			tgt_s4 <= tgt_s3;
			acc_s4 <= sat_c;
		end
	end

endmodule

/* sv/htp_drive_out.sv */
// Output stage: drive clamp, wheel signs and the result register with the done follow-up.
`timescale 1ns / 1ps

module htp_drive_out #(
	parameter int ANGLE_FRAC_BITS = htp_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int COEF_FRAC_BITS  = htp_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_v,
	output logic                               in_take,
	input  htp_pkg::item_ctl_t                 ctl_s4,
	input  logic [htp_pkg::TARGET_W-1:0]       tgt_s4,
	input  logic signed [htp_pkg::ACC_W-1:0]   acc_s4,
	input  logic [htp_pkg::LIMIT_W-1:0]        drive_limit,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic signed [htp_pkg::DRIVE_W-1:0] left_q,
	output logic signed [htp_pkg::DRIVE_W-1:0] right_q,
	output logic [htp_pkg::TARGET_W-1:0]       tgt_q,
	output logic                               done_q,
	output logic                               last_q
);

	localparam int SH = COEF_FRAC_BITS + ANGLE_FRAC_BITS;
	localparam int AW = htp_pkg::ACC_W;
	localparam int DW = htp_pkg::DRIVE_W;

	logic                        out_v_q;
	logic                        pend_q;
	logic                        load;
	logic                        second;
	logic signed [AW-1:0]        lim_c;
	logic [AW-1:0]               mag_c;
	logic [AW-1:0]               shr_c;
	logic [htp_pkg::LIMIT_W-1:0] um_c;
	logic                        uneg_c;
	logic                        rneg_c;
	logic [DW-1:0]               mag16_c;
	logic signed [DW-1:0]        left_c;
	logic signed [DW-1:0]        right_c;
	logic                        done_c;
	logic                        last_c;

	// A turn that finishes sends its drive result, then a zero-drive done result.
	assign second   = out_v_q && m_tready && pend_q;
	assign in_take  = !out_v_q || (m_tready && !pend_q);
	assign load     = in_v && in_take;
	assign m_tvalid = out_v_q;

	always_comb begin
		lim_c  = signed'(AW'(drive_limit) << SH);
		mag_c  = acc_s4[AW-1] ? -acc_s4 : acc_s4;
		shr_c  = mag_c >> SH;
		uneg_c = acc_s4[AW-1];
		if (acc_s4 > lim_c) begin
			um_c = drive_limit;
		end else if (acc_s4 < -lim_c) begin
			um_c = drive_limit;
		end else begin
			um_c = shr_c[htp_pkg::LIMIT_W-1:0];
		end
		rneg_c  = uneg_c ^ ctl_s4.neg;
		mag16_c = {1'b0, um_c};
		right_c = rneg_c ? -mag16_c : mag16_c;
		left_c  = rneg_c ? mag16_c : -mag16_c;
		done_c  = 1'b0;
		last_c  = 1'b1;
		case (ctl_s4.kind)
			htp_pkg::KIND_PID: begin
				last_c = !ctl_s4.done;
			end
			htp_pkg::KIND_IDLE: begin
				left_c  = '0;
				right_c = '0;
				done_c  = 1'b1;
			end
			default: begin
				left_c  = '0;
				right_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (second) begin
			pend_q <= 1'b0;
		end else if (in_take) begin
			out_v_q <= in_v;
			pend_q  <= in_v && (ctl_s4.kind == htp_pkg::KIND_PID) && ctl_s4.done;
		end
	end

	always_ff @(posedge clk) begin
		if (second) begin
			left_q  <= '0;
			right_q <= '0;
			done_q  <= 1'b1;
			last_q  <= 1'b1;
		end else if (load) begin
			left_q  <= left_c;
			right_q <= right_c;
			tgt_q   <= tgt_s4;
			done_q  <= done_c;
			last_q  <= last_c;
		end
	end

endmodule

/* sv/heading_turn_pid_core.sv */
// Top level of the heading turn PID core: configuration, input register and stage chain.
// Items pass the input register, then the snap, PID error, accumulator and output stages.
// Throughput: one input item per cycle unless m_tready holds the output; an item that finishes
// a turn gives two results and holds the output register until the second is taken.
// Reset: arst_n clears all stage valids, the turn and PID state, and loads the register
// defaults; no memory needs clearing, so items are taken right after reset.
`timescale 1ns / 1ps

module heading_turn_pid_core #(
	parameter int ANGLE_FRAC_BITS = htp_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int COEF_FRAC_BITS  = htp_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [htp_pkg::IN_DATA_W-1:0]     s_tdata,   // turn_direction[1:0], heading[18:2]
	input  logic [0:0]                        s_tuser,   // command[0]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [htp_pkg::OUT_DATA_W-1:0]    m_tdata,   // left_drive[15:0], right_drive[31:16],
	                                                     // target_heading[40:32]
	output logic [0:0]                        m_tuser,   // done_res[0]
	output logic                              m_tlast,
	input  logic                              cfg_we,
	input  logic [htp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [htp_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int TW = htp_pkg::turn_w(ANGLE_FRAC_BITS);
	localparam int EW = htp_pkg::err_w(ANGLE_FRAC_BITS);
	localparam int PW = htp_pkg::COEF_W + EW;

	htp_pkg::cfg_t                         cfg_q;

	logic                                  v_s1;
	logic                                  take_s1;
	htp_pkg::cmd_t                         cmd_s1;
	logic [htp_pkg::DIR_W-1:0]             dir_s1;
	logic signed [htp_pkg::HEADING_W-1:0]  heading_s1;

	logic                                  take_s2;
	logic                                  v_s2;
	htp_pkg::cmd_t                         cmd_s2;
	logic                                  neg_s2;
	logic signed [htp_pkg::HEADING_W-1:0]  heading_s2;
	logic signed [TW-1:0]                  tsn_s2;
	logic [TW-1:0]                         q_s2;

	logic                                  take_s3;
	logic                                  v_s3;
	htp_pkg::item_ctl_t                    ctl_s3;
	logic [htp_pkg::TARGET_W-1:0]          tgt_s3;
	logic signed [PW-1:0]                  p0_s3;
	logic signed [PW-1:0]                  p1_s3;
	logic signed [PW-1:0]                  p2_s3;

	logic                                  take_s4;
	logic                                  v_s4;
	htp_pkg::item_ctl_t                    ctl_s4;
	logic [htp_pkg::TARGET_W-1:0]          tgt_s4;
	logic signed [htp_pkg::ACC_W-1:0]      acc_s4;

	logic                                  take_out;
	logic signed [htp_pkg::DRIVE_W-1:0]    left_q;
	logic signed [htp_pkg::DRIVE_W-1:0]    right_q;
	logic [htp_pkg::TARGET_W-1:0]          tgt_q;
	logic                                  done_q;
	logic                                  last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef_now    <= htp_pkg::COEF_NOW_RST;
			cfg_q.coef_prev   <= htp_pkg::COEF_PREV_RST;
			cfg_q.coef_prev2  <= htp_pkg::COEF_PREV2_RST;
			cfg_q.drive_limit <= htp_pkg::DRIVE_LIMIT_RST;
			cfg_q.done_window <= htp_pkg::DONE_WINDOW_RST;
			cfg_q.snap_window <= htp_pkg::SNAP_WINDOW_RST;
		end else if (cfg_we) begin
			case (htp_pkg::cfg_idx_t'(cfg_index))
				htp_pkg::CFG_COEF_NOW:    cfg_q.coef_now    <= cfg_data;
				htp_pkg::CFG_COEF_PREV:   cfg_q.coef_prev   <= cfg_data;
				htp_pkg::CFG_COEF_PREV2:  cfg_q.coef_prev2  <= cfg_data;
				htp_pkg::CFG_DRIVE_LIMIT: cfg_q.drive_limit <= cfg_data[htp_pkg::LIMIT_W-1:0];
				htp_pkg::CFG_DONE_WINDOW: cfg_q.done_window <= cfg_data[htp_pkg::DONE_WIN_W-1:0];
				htp_pkg::CFG_SNAP_WINDOW: cfg_q.snap_window <= cfg_data[htp_pkg::SNAP_WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register; each stage takes a new item when empty or when its item moves on.
	assign take_s1  = !v_s1 || take_s2;
	assign s_tready = take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take_s1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && take_s1) begin
			cmd_s1     <= htp_pkg::cmd_t'(s_tuser);
			dir_s1     <= s_tdata[htp_pkg::DIR_W-1:0];
			heading_s1 <= s_tdata[htp_pkg::DIR_W +: htp_pkg::HEADING_W];
		end
	end

	htp_snap #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_snap (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_v       (v_s1),
		.in_take    (take_s2),
		.in_cmd     (cmd_s1),
		.in_dir     (dir_s1),
		.in_heading (heading_s1),
		.snap_window(cfg_q.snap_window),
		.out_v      (v_s2),
		.out_take   (take_s3),
		.cmd_s2     (cmd_s2),
		.neg_s2     (neg_s2),
		.heading_s2 (heading_s2),
		.tsn_s2     (tsn_s2),
		.q_s2       (q_s2)
	);

	htp_pid_err #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_pid_err (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_v      (v_s2),
		.in_take   (take_s3),
		.cmd_s2    (cmd_s2),
		.neg_s2    (neg_s2),
		.heading_s2(heading_s2),
		.tsn_s2    (tsn_s2),
		.q_s2      (q_s2),
		.cfg       (cfg_q),
		.out_v     (v_s3),
		.out_take  (take_s4),
		.ctl_s3    (ctl_s3),
		.tgt_s3    (tgt_s3),
		.p0_s3     (p0_s3),
		.p1_s3     (p1_s3),
		.p2_s3     (p2_s3)
	);

	htp_accum #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_v    (v_s3),
		.in_take (take_s4),
		.ctl_s3  (ctl_s3),
		.tgt_s3  (tgt_s3),
		.p0_s3   (p0_s3),
		.p1_s3   (p1_s3),
		.p2_s3   (p2_s3),
		.out_v   (v_s4),
		.out_take(take_out),
		.ctl_s4  (ctl_s4),
		.tgt_s4  (tgt_s4),
		.acc_s4  (acc_s4)
	);

	htp_drive_out #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_drive_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_v       (v_s4),
		.in_take    (take_out),
		.ctl_s4     (ctl_s4),
		.tgt_s4     (tgt_s4),
		.acc_s4     (acc_s4),
		.drive_limit(cfg_q.drive_limit),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.left_q     (left_q),
		.right_q    (right_q),
		.tgt_q      (tgt_q),
		.done_q     (done_q),
		.last_q     (last_q)
	);

	assign m_tdata = {{(htp_pkg::OUT_DATA_W - 2*htp_pkg::DRIVE_W - htp_pkg::TARGET_W){1'b0}},
	                  tgt_q, right_q, left_q};
	assign m_tuser = done_q;
	assign m_tlast = last_q;

	// A drive result that is not last is always followed by the done result.
	ap_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tuser[0] && m_tlast))
		else $error("done result did not follow a non-last drive result");

	ap_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[2*htp_pkg::DRIVE_W-1:0] == '0))
		else $error("done result carries a nonzero drive");

	ap_opposite: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[htp_pkg::DRIVE_W-1:0]) ==
		              -$signed(m_tdata[2*htp_pkg::DRIVE_W-1:htp_pkg::DRIVE_W])))
		else $error("wheel drives are not opposite");

	ap_target_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2*htp_pkg::DRIVE_W +: htp_pkg::TARGET_W] <
		              htp_pkg::TARGET_W'(htp_pkg::DEG_FULL)))
		else $error("target heading out of range");

endmodule
